// ===== hdl/fldr_pkg.sv =====
// Package for the fax line downscaler: field structs, widths, register and
// operation codes, controller/datapath command and status bundles.
// Depends on nothing; every other file of the block uses it.
package fldr_pkg;

	localparam int unsigned DISPLAY_ROWS      = 190;
	localparam int unsigned MAX_DISPLAY_WIDTH = 512;

	localparam int unsigned CFG_W   = 12;
	localparam int unsigned PIX_W   = 8;
	localparam int unsigned COLOR_W = 16;
	localparam int unsigned COL_W   = 9;
	localparam int unsigned ROW_W   = 8;
	localparam int unsigned IDX_W   = 12;
	localparam int unsigned TCOL_W  = 10;
	localparam int unsigned SUM_W   = 16;
	localparam int unsigned CNT_W   = 12;
	localparam int unsigned PROD_W  = 25;
	localparam int unsigned PADDR_W = 3;
	localparam int unsigned PDATA_W = 32;

	localparam logic [CFG_W-1:0] SW_RESET = 12'd1809;
	localparam logic [CFG_W-1:0] DW_RESET = 12'd400;

	typedef enum logic {
		REG_SOURCE_WIDTH  = 1'b0,
		REG_DISPLAY_WIDTH = 1'b1
	} reg_idx_t;

	typedef enum logic {
		OP_PIXEL     = 1'b0,
		OP_NEW_IMAGE = 1'b1
	} op_t;

	typedef struct packed {
		op_t              operation;
		logic [PIX_W-1:0] pixel;
		logic             line_end;
	} item_t;

	typedef struct packed {
		logic [COLOR_W-1:0] color;
		logic [COL_W-1:0]   column;
		logic [ROW_W-1:0]   row;
		logic               row_end;
		logic               wrapped;
	} result_t;

	typedef struct packed {
		logic load_item;
		logic mul;
		logic update;
		logic div_start;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic close;
		logic div_done;
	} status_t;

	// gray>>3 in red and blue, gray>>2 in green
	function automatic logic [COLOR_W-1:0] rgb565(input logic [PIX_W-1:0] gray);
		return {gray[7:3], gray[7:2], gray[7:3]};
	endfunction

endpackage

// ===== hdl/fldr_regs.sv =====
// APB-style register file holding source_width and display_width.
// Depends on fldr_pkg.
module fldr_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [fldr_pkg::PADDR_W-1:0]   paddr,
	input  logic [fldr_pkg::PDATA_W-1:0]   pwdata,
	output logic [fldr_pkg::PDATA_W-1:0]   prdata,
	output logic                           pready,
	output logic [fldr_pkg::CFG_W-1:0]     source_width,
	output logic [fldr_pkg::CFG_W-1:0]     display_width
);

	logic [fldr_pkg::CFG_W-1:0] sw_q;
	logic [fldr_pkg::CFG_W-1:0] dw_q;
	fldr_pkg::reg_idx_t         idx;

	assign idx    = fldr_pkg::reg_idx_t'(paddr[2]);
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sw_q <= fldr_pkg::SW_RESET;
			dw_q <= fldr_pkg::DW_RESET;
		end else if (psel && penable && pwrite) begin
			unique case (idx)
				fldr_pkg::REG_SOURCE_WIDTH:  sw_q <= pwdata[fldr_pkg::CFG_W-1:0];
				fldr_pkg::REG_DISPLAY_WIDTH: dw_q <= pwdata[fldr_pkg::CFG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			fldr_pkg::REG_SOURCE_WIDTH:
				prdata = {{(fldr_pkg::PDATA_W-fldr_pkg::CFG_W){1'b0}}, sw_q};
			fldr_pkg::REG_DISPLAY_WIDTH:
				prdata = {{(fldr_pkg::PDATA_W-fldr_pkg::CFG_W){1'b0}}, dw_q};
			default:
				prdata = '0;
		endcase
	end

	assign source_width  = sw_q;
	assign display_width = dw_q;

endmodule

// ===== hdl/fldr_div.sv =====
// Restoring divider, one quotient bit per cycle, eight quotient bits per bin average.
// Quotient is known to fit 8 bits (dividend < divisor * 256). Depends on fldr_pkg.
module fldr_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [fldr_pkg::SUM_W-1:0]    dividend,
	input  logic [fldr_pkg::CNT_W-1:0]    divisor,
	output logic                          done,
	output logic [fldr_pkg::PIX_W-1:0]    quotient
);

	logic                          busy_q;
	logic [2:0]                    step_q;
	logic [fldr_pkg::CNT_W-1:0]    rem_q;
	logic [fldr_pkg::CNT_W-1:0]    dvs_q;
	logic [fldr_pkg::PIX_W-1:0]    low_q;
	logic [fldr_pkg::PIX_W-1:0]    quo_q;
	logic [fldr_pkg::CNT_W:0]      trial;
	logic [fldr_pkg::CNT_W:0]      diff;
	logic                          fits;

	assign trial = {rem_q, low_q[fldr_pkg::PIX_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};
	assign diff  = trial - {1'b0, dvs_q};
	assign done  = busy_q && (step_q == 3'd7);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + 3'd1;
			if (step_q == 3'd7) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			// high byte is below the divisor, so it seeds the remainder
			rem_q <= {{(fldr_pkg::CNT_W-fldr_pkg::PIX_W){1'b0}}, dividend[15:8]};
			low_q <= dividend[7:0];
			dvs_q <= divisor;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? diff[fldr_pkg::CNT_W-1:0] : trial[fldr_pkg::CNT_W-1:0];
			low_q <= {low_q[fldr_pkg::PIX_W-2:0], 1'b0};
			quo_q <= {quo_q[fldr_pkg::PIX_W-2:0], fits};
		end
	end

	assign quotient = quo_q;

endmodule

// ===== hdl/fldr_dp.sv =====
// Datapath: row/column scaling state, bin accumulator, cross-multiply test,
// divider and the output register. Depends on fldr_pkg and fldr_div.
module fldr_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  fldr_pkg::cmd_t                cmd,
	input  fldr_pkg::item_t               item,
	input  logic [fldr_pkg::CFG_W-1:0]    source_width,
	input  logic [fldr_pkg::CFG_W-1:0]    display_width,
	output fldr_pkg::status_t             status,
	output fldr_pkg::result_t             result
);

	localparam logic [fldr_pkg::ROW_W:0]   ROWS_LIM = (fldr_pkg::ROW_W+1)'(fldr_pkg::DISPLAY_ROWS);
	localparam logic [fldr_pkg::CFG_W-1:0] DW_LIM   =
		fldr_pkg::CFG_W'(fldr_pkg::MAX_DISPLAY_WIDTH);
	localparam logic [fldr_pkg::IDX_W-1:0] IDX_MAX  = '1;
	localparam logic [fldr_pkg::CNT_W-1:0] CNT_MAX  = '1;

	// item register
	fldr_pkg::item_t                item_q;

	// scaling state
	logic [fldr_pkg::CFG_W-1:0]     frac_q;
	logic [fldr_pkg::ROW_W-1:0]     cur_row_q;
	logic                           drawn_q;
	logic                           wrapped_q;
	logic [fldr_pkg::IDX_W-1:0]     src_idx_q;
	logic [fldr_pkg::TCOL_W-1:0]    tcol_q;
	logic [fldr_pkg::SUM_W-1:0]     sum_q;
	logic [fldr_pkg::CNT_W-1:0]     cnt_q;

	// products of the bin-close test
	logic [fldr_pkg::PROD_W-1:0]    prod_a_q;
	logic [fldr_pkg::PROD_W-1:0]    prod_b_q;

	// fields of the pending result
	logic [fldr_pkg::COL_W-1:0]     p_col_q;
	logic [fldr_pkg::ROW_W-1:0]     p_row_q;
	logic                           p_end_q;
	logic                           p_wrap_q;
	logic                           p_zero_q;
	fldr_pkg::result_t              result_q;

	logic [fldr_pkg::IDX_W:0]       idx_p1;
	logic [fldr_pkg::TCOL_W:0]      tcol_p1;
	logic                           widths_ok;
	logic [fldr_pkg::CFG_W:0]       acc;
	logic [fldr_pkg::CFG_W:0]       acc_sub;
	logic [fldr_pkg::CFG_W:0]       acc_new;
	logic                           advance;
	logic                           drawing;
	logic                           active;
	logic [fldr_pkg::ROW_W:0]       row_p1;
	logic                           wraps;
	logic [fldr_pkg::ROW_W-1:0]     row_next;
	logic [fldr_pkg::SUM_W-1:0]     sum_n;
	logic [fldr_pkg::CNT_W-1:0]     cnt_n;
	logic                           close;
	logic                           div_done;
	logic [fldr_pkg::PIX_W-1:0]     quotient;
	logic [fldr_pkg::PIX_W-1:0]     gray;

	assign idx_p1    = {1'b0, src_idx_q} + (fldr_pkg::IDX_W+1)'(1);
	assign tcol_p1   = {1'b0, tcol_q} + (fldr_pkg::TCOL_W+1)'(1);
	assign widths_ok = (source_width != '0) && (display_width != '0);
	assign acc       = {1'b0, frac_q} + {1'b0, display_width};
	assign advance   = widths_ok && (acc >= {1'b0, source_width});
	assign drawing   = advance && (display_width <= DW_LIM);
	assign active    = drawing &&
		({{(fldr_pkg::CFG_W-fldr_pkg::TCOL_W){1'b0}}, tcol_q} < display_width);
	assign acc_sub   = acc - {1'b0, source_width};
	assign acc_new   = !advance ? acc :
		(acc_sub >= {1'b0, source_width}) ? ({1'b0, source_width} - 13'd1) : acc_sub;

	assign row_p1    = {1'b0, cur_row_q} + (fldr_pkg::ROW_W+1)'(1);
	assign wraps     = drawn_q && (row_p1 >= ROWS_LIM);
	assign row_next  = (!drawn_q || wraps) ? '0 : row_p1[fldr_pkg::ROW_W-1:0];

	assign sum_n     = sum_q + {{(fldr_pkg::SUM_W-fldr_pkg::PIX_W){1'b0}}, item_q.pixel};
	assign cnt_n     = (cnt_q < CNT_MAX) ? cnt_q + fldr_pkg::CNT_W'(1) : cnt_q;
	assign close     = (item_q.operation == fldr_pkg::OP_PIXEL) && active &&
		(prod_a_q >= prod_b_q);

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			item_q <= item;
		end
		if (cmd.mul) begin
			prod_a_q <= fldr_pkg::PROD_W'(idx_p1) * fldr_pkg::PROD_W'(display_width);
			prod_b_q <= fldr_pkg::PROD_W'(tcol_p1) * fldr_pkg::PROD_W'(source_width);
		end
		if (cmd.update && close) begin
			p_col_q  <= tcol_q[fldr_pkg::COL_W-1:0];
			p_row_q  <= row_next;
			p_end_q  <= ({{(fldr_pkg::CFG_W-fldr_pkg::TCOL_W-1){1'b0}}, tcol_p1} ==
				display_width);
			p_wrap_q <= wrapped_q || wraps;
			p_zero_q <= (cnt_n == '0);
		end
		if (cmd.out_load) begin
			result_q <= '{color: fldr_pkg::rgb565(gray), column: p_col_q, row: p_row_q,
				row_end: p_end_q, wrapped: p_wrap_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frac_q    <= '0;
			cur_row_q <= '0;
			drawn_q   <= 1'b0;
			wrapped_q <= 1'b0;
			src_idx_q <= '0;
			tcol_q    <= '0;
			sum_q     <= '0;
			cnt_q     <= '0;
		end else if (cmd.update) begin
			priority if (item_q.operation == fldr_pkg::OP_NEW_IMAGE) begin
				frac_q    <= '0;
				cur_row_q <= '0;
				drawn_q   <= 1'b0;
				wrapped_q <= 1'b0;
				src_idx_q <= '0;
				tcol_q    <= '0;
				sum_q     <= '0;
				cnt_q     <= '0;
			end else if (item_q.line_end) begin
				if (widths_ok) begin
					frac_q <= acc_new[fldr_pkg::CFG_W-1:0];
					if (advance) begin
						cur_row_q <= row_next;
						drawn_q   <= 1'b1;
						if (wraps) begin
							wrapped_q <= 1'b1;
						end
					end
				end
				src_idx_q <= '0;
				tcol_q    <= '0;
				sum_q     <= '0;
				cnt_q     <= '0;
			end else begin
				if (src_idx_q < IDX_MAX) begin
					src_idx_q <= idx_p1[fldr_pkg::IDX_W-1:0];
				end
				if (close) begin
					tcol_q <= tcol_p1[fldr_pkg::TCOL_W-1:0];
					sum_q  <= '0;
					cnt_q  <= '0;
				end else if (active) begin
					sum_q <= sum_n;
					cnt_q <= cnt_n;
				end
			end
		end
	end

	fldr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (sum_n),
		.divisor  (cnt_n),
		.done     (div_done),
		.quotient (quotient)
	);

	// empty bin reads as white
	assign gray   = p_zero_q ? '1 : quotient;

	assign status = '{close: close, div_done: div_done};
	assign result = result_q;

endmodule

// ===== hdl/fldr_ctrl.sv =====
// Controller: sequences one request through multiply and update and, when it
// closes a bin, divide and output load; owns the handshakes. Depends on fldr_pkg.
module fldr_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_ready,
	output logic                 result_valid,
	input  logic                 result_ready,
	input  fldr_pkg::status_t    status,
	output fldr_pkg::cmd_t       cmd
);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_MUL  = 5'b00010,
		S_UPD  = 5'b00100,
		S_DIV  = 5'b01000,
		S_OUT  = 5'b10000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   valid_q;
	logic   out_free;

	assign out_free = !valid_q || result_ready;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (item_valid) begin
					cmd.load_item = 1'b1;
					state_d       = S_MUL;
				end
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_UPD;
			end
			S_UPD: begin
				cmd.update = 1'b1;
				if (status.close) begin
					cmd.div_start = 1'b1;
					state_d       = S_DIV;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_DIV: begin
				if (status.div_done) begin
					state_d = S_OUT;
				end
			end
			S_OUT: begin
				// hold until the output register frees up
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				valid_q <= 1'b1;
			end else if (result_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	assign item_ready   = (state_q == S_IDLE);
	assign result_valid = valid_q;

endmodule

// ===== hdl/fax_line_downscaler_rgb565.sv =====
// Top level of the fax line downscaler: register file, controller, datapath.
// Depends on fldr_pkg, fldr_regs, fldr_ctrl, fldr_dp (and fldr_div below it).
//
//   channel  | signals                                     | moves
//   ---------+---------------------------------------------+-----------------------
//   item     | item_valid, item_ready, item (item_t)       | source pixel / new image
//   result   | result_valid, result_ready, result          | RGB565 pixel with place
//   config   | psel, penable, pwrite, paddr, pwdata, prdata | width registers
//
// A request that closes no bin goes through load, multiply and update; one that
// closes a bin then waits on the bit-serial divider that forms the bin average.
// The result sits in an output register, so a new request is taken while it waits;
// a stalled result only holds the controller once the next average is ready.
// Reset is asynchronous, active low, and clears all scaling state at once.
module fax_line_downscaler_rgb565 (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [fldr_pkg::PADDR_W-1:0]  paddr,
	input  logic [fldr_pkg::PDATA_W-1:0]  pwdata,
	output logic [fldr_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready,
	input  logic                          item_valid,
	output logic                          item_ready,
	input  fldr_pkg::item_t               item,
	output logic                          result_valid,
	input  logic                          result_ready,
	output fldr_pkg::result_t             result
);

	logic [fldr_pkg::CFG_W-1:0] source_width;
	logic [fldr_pkg::CFG_W-1:0] display_width;
	fldr_pkg::cmd_t             cmd;
	fldr_pkg::status_t          status;

	fldr_regs u_regs (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.source_width  (source_width),
		.display_width (display_width)
	);

	fldr_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.status       (status),
		.cmd          (cmd)
	);

	fldr_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.item          (item),
		.source_width  (source_width),
		.display_width (display_width),
		.status        (status),
		.result        (result)
	);

endmodule

// ===== hdl/fldr_checker.sv =====
// Port-level checker for the fax line downscaler, bound to the top level.
// Depends on fldr_pkg.
module fldr_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               item_valid,
	input logic               item_ready,
	input logic               result_valid,
	input logic               result_ready,
	input fldr_pkg::result_t  result
);

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result dropped or changed while stalled");

	a_one_request: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> !item_ready)
		else $error("request taken while previous one still in work");

	a_gray_color: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.color[15:11] == result.color[4:0]) &&
			(result.color[10:6] == result.color[15:11]))
		else $error("color is not a gray RGB565 value");

	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> ({1'b0, result.row} <
			(fldr_pkg::ROW_W+1)'(fldr_pkg::DISPLAY_ROWS)))
		else $error("row beyond display height");

endmodule

bind fax_line_downscaler_rgb565 fldr_checker u_fldr_checker (.*);

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// Testbench for fax_line_downscaler_rgb565: drives pixel and new-image requests
// plus width register writes, predicts every RGB565 pixel and checks results in order.
// Depends on fldr_pkg and the RTL of the block.
module tb;

	localparam int unsigned RAND_ITEMS = 1950;
	localparam int unsigned IDLE_TAIL  = 24;
	localparam int unsigned MAX_REPORT = 10;

	typedef enum {
		PH_SAME, PH_DOWN, PH_UP, PH_WIDE, PH_ZERO, PH_EXTREME, PH_WRAP, PH_BIN_WRAP
	} phase_t;

	typedef struct packed {
		bit                         is_cfg;
		fldr_pkg::reg_idx_t         ridx;
		logic [fldr_pkg::CFG_W-1:0] val;
		fldr_pkg::item_t            it;
		bit                         typed;
		fldr_pkg::result_t          res;
	} dir_row_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          psel = 1'b0;
	logic                          penable = 1'b0;
	logic                          pwrite = 1'b0;
	logic [fldr_pkg::PADDR_W-1:0]  paddr = '0;
	logic [fldr_pkg::PDATA_W-1:0]  pwdata = '0;
	logic [fldr_pkg::PDATA_W-1:0]  prdata;
	logic                          pready;
	logic                          item_valid = 1'b0;
	logic                          item_ready;
	fldr_pkg::item_t               item = '0;
	logic                          result_valid;
	logic                          result_ready = 1'b0;
	fldr_pkg::result_t             result;

	fax_line_downscaler_rgb565 u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// downscaler state as predicted
	logic [fldr_pkg::CFG_W-1:0]  p_sw, p_dw;
	logic [fldr_pkg::CFG_W-1:0]  row_acc;
	logic [fldr_pkg::ROW_W-1:0]  last_row;
	bit                          row_seen;
	logic [fldr_pkg::IDX_W-1:0]  src_pos;
	logic [fldr_pkg::TCOL_W-1:0] out_col;
	logic [fldr_pkg::SUM_W-1:0]  bin_total;
	logic [fldr_pkg::CNT_W-1:0]  bin_pixels;
	bit                          rows_wrapped;

	fldr_pkg::result_t expected_px[$];
	dir_row_t          dir_rows[$];
	int unsigned       mismatches = 0;
	int unsigned       items_sent = 0;
	int unsigned       in_gap_max = 18;
	int unsigned       out_gap_max = 18;

	function automatic void add_row(input dir_row_t row_v);
		dir_rows.insert(dir_rows.size(), row_v);
	endfunction

	function automatic void expect_px(input fldr_pkg::result_t px);
		expected_px.insert(expected_px.size(), px);
	endfunction

	function automatic void clear_line_state();
		src_pos = '0;
		out_col = '0;
		bin_total = '0;
		bin_pixels = '0;
	endfunction

	function automatic void clear_image_state();
		row_acc = '0;
		last_row = '0;
		row_seen = 1'b0;
		rows_wrapped = 1'b0;
		clear_line_state();
	endfunction

	// Advance the model by one request; return 1 when it yields a pixel.
	function automatic bit downscale_pixel(input fldr_pkg::item_t it,
			output fldr_pkg::result_t r);
		int unsigned sw, dw, nxt, acc, avg, g5, g6;
		bit ok, adv, draw, wraps, got;
		sw = p_sw;
		dw = p_dw;
		ok = (sw != 0) && (dw != 0);
		adv = ok && (32'(row_acc) + dw >= sw);
		draw = adv && (dw <= fldr_pkg::MAX_DISPLAY_WIDTH);
		wraps = 1'b0;
		nxt = 0;
		if (row_seen) begin
			nxt = 32'(last_row) + 1;
			if (nxt >= fldr_pkg::DISPLAY_ROWS) begin
				nxt = 0;
				wraps = 1'b1;
			end
		end
		got = 1'b0;
		r = '0;
		if (it.operation == fldr_pkg::OP_NEW_IMAGE) begin
			clear_image_state();
			return 1'b0;
		end
		if (draw && 32'(out_col) < dw) begin
			bin_total = bin_total + fldr_pkg::SUM_W'(it.pixel);
			if (bin_pixels != '1)
				bin_pixels = bin_pixels + fldr_pkg::CNT_W'(1);
			// close the bin once the source position passes the column edge
			if ((32'(src_pos) + 1) * dw >= (32'(out_col) + 1) * sw) begin
				avg = (bin_pixels != 0) ? (32'(bin_total) / 32'(bin_pixels)) : 255;
				avg = avg & 32'hFF;
				g5 = avg >> 3;
				g6 = avg >> 2;
				r.color = 16'((g5 << 11) | (g6 << 5) | g5);
				r.column = out_col[fldr_pkg::COL_W-1:0];
				r.row = nxt[fldr_pkg::ROW_W-1:0];
				r.row_end = (32'(out_col) + 1 == dw);
				r.wrapped = rows_wrapped || wraps;
				got = 1'b1;
				out_col = out_col + fldr_pkg::TCOL_W'(1);
				bin_total = '0;
				bin_pixels = '0;
			end
		end
		if (src_pos != '1)
			src_pos = src_pos + fldr_pkg::IDX_W'(1);
		if (it.line_end) begin
			if (ok) begin
				acc = 32'(row_acc) + dw;
				if (adv) begin
					last_row = nxt[fldr_pkg::ROW_W-1:0];
					row_seen = 1'b1;
					if (wraps)
						rows_wrapped = 1'b1;
					acc = acc - sw;
					if (acc >= sw)
						acc = sw - 1;
				end
				row_acc = acc[fldr_pkg::CFG_W-1:0];
			end
			clear_line_state();
		end
		return got;
	endfunction

	function automatic void tab_item(input fldr_pkg::op_t op,
			input logic [fldr_pkg::PIX_W-1:0] pix, input bit last);
		dir_row_t row_v;
		row_v = '0;
		row_v.it.operation = op;
		row_v.it.pixel = pix;
		row_v.it.line_end = last;
		add_row(row_v);
	endfunction

	function automatic void tab_cfg(input fldr_pkg::reg_idx_t idx,
			input logic [fldr_pkg::CFG_W-1:0] val);
		dir_row_t row_v;
		row_v = '0;
		row_v.is_cfg = 1'b1;
		row_v.ridx = idx;
		row_v.val = val;
		add_row(row_v);
	endfunction

	// attach a literal expectation to the last request of the table
	function automatic void tab_result(input logic [fldr_pkg::COLOR_W-1:0] color,
			input logic [fldr_pkg::COL_W-1:0] col, input logic [fldr_pkg::ROW_W-1:0] rw,
			input bit rend, input bit wrp);
		int unsigned k;
		k = dir_rows.size() - 1;
		dir_rows[k].typed = 1'b1;
		dir_rows[k].res.color = color;
		dir_rows[k].res.column = col;
		dir_rows[k].res.row = rw;
		dir_rows[k].res.row_end = rend;
		dir_rows[k].res.wrapped = wrp;
	endfunction

	task automatic apb_xfer(input fldr_pkg::reg_idx_t idx, input bit wr,
			input logic [fldr_pkg::PDATA_W-1:0] wdata,
			output logic [fldr_pkg::PDATA_W-1:0] rdata);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {idx, 2'b00};
		pwdata <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		rdata = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic check_reg(input fldr_pkg::reg_idx_t idx,
			input logic [fldr_pkg::CFG_W-1:0] want);
		logic [fldr_pkg::PDATA_W-1:0] rd;
		apb_xfer(idx, 1'b0, '0, rd);
		if (rd[fldr_pkg::CFG_W-1:0] !== want) begin
			mismatches++;
			if (mismatches <= MAX_REPORT)
				$display("mismatch: width register %0d reads %0d, expected %0d",
					idx, rd[fldr_pkg::CFG_W-1:0], want);
		end
	endtask

	task automatic write_width(input fldr_pkg::reg_idx_t idx,
			input logic [fldr_pkg::CFG_W-1:0] val);
		logic [fldr_pkg::PDATA_W-1:0] rd;
		// upper bits are don't-care; toggle them anyway
		apb_xfer(idx, 1'b1, {20'($urandom), val}, rd);
		check_reg(idx, val);
		if (idx == fldr_pkg::REG_SOURCE_WIDTH)
			p_sw = val;
		else
			p_dw = val;
	endtask

	// Drop valid, wait for every pending pixel, then let the pipeline settle.
	task automatic drain_px();
		item_valid <= 1'b0;
		while (expected_px.size() != 0) @(posedge clk);
		repeat (IDLE_TAIL) @(posedge clk);
	endtask

	task automatic send_item(input fldr_pkg::item_t it, input bit typed,
			input fldr_pkg::result_t res);
		int unsigned gap;
		fldr_pkg::result_t pred;
		bit got;
		gap = $urandom_range(0, in_gap_max);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item <= it;
		item_valid <= 1'b1;
		do @(posedge clk); while (item_ready !== 1'b1);
		got = downscale_pixel(it, pred);
		if (typed)
			expect_px(res);
		else if (got)
			expect_px(pred);
		items_sent++;
	endtask

	task automatic send_line(input int unsigned len, input bit noisy, input bit heavy);
		fldr_pkg::item_t it;
		fldr_pkg::result_t none;
		int unsigned pos, r;
		none = '0;
		pos = $urandom_range(0, len - 1);
		for (int unsigned i = 0; i < len; i++) begin
			if (noisy && i == pos) begin
				it.operation = fldr_pkg::OP_NEW_IMAGE;
				it.pixel = 8'($urandom);
				it.line_end = 1'($urandom);
				send_item(it, 1'b0, none);
			end
			r = $urandom_range(0, 99);
			it.operation = fldr_pkg::OP_PIXEL;
			if (heavy)
				it.pixel = (r < 90) ? 8'hFF : 8'($urandom);
			else if (r < 10)
				it.pixel = 8'h00;
			else if (r < 20)
				it.pixel = 8'hFF;
			else
				it.pixel = 8'($urandom);
			it.line_end = (i == len - 1);
			send_item(it, 1'b0, none);
		end
	endtask

	function automatic int unsigned pick_gap();
		case ($urandom_range(0, 3))
			0: return 0;
			1: return 3;
			default: return 18;
		endcase
	endfunction

	initial begin : result_sink
		int unsigned stall;
		fldr_pkg::result_t want;
		forever begin
			stall = $urandom_range(0, out_gap_max);
			if (stall > 0) begin
				result_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_ready <= 1'b1;
			do @(posedge clk); while (result_valid !== 1'b1);
			if (expected_px.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORT)
					$display("mismatch: unexpected pixel color %h column %0d row %0d",
						result.color, result.column, result.row);
			end else begin
				want = expected_px.pop_front();
				if (result.color !== want.color || result.column !== want.column ||
						result.row !== want.row || result.row_end !== want.row_end ||
						result.wrapped !== want.wrapped) begin
					mismatches++;
					if (mismatches <= MAX_REPORT)
						$display({"mismatch: color %h/%h column %0d/%0d row %0d/%0d",
							" row_end %b/%b wrapped %b/%b (expected/actual)"},
							want.color, result.color, want.column, result.column,
							want.row, result.row, want.row_end, result.row_end,
							want.wrapped, result.wrapped);
				end
			end
		end
	end

	initial begin : stimulus
		int unsigned start, n_lines, len, base, r, phase_no;
		logic [fldr_pkg::CFG_W-1:0] sw, dw;
		bit noisy;
		phase_t ph;
		fldr_pkg::item_t it;
		fldr_pkg::result_t none;

		none = '0;
		p_sw = fldr_pkg::SW_RESET;
		p_dw = fldr_pkg::DW_RESET;
		clear_image_state();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		check_reg(fldr_pkg::REG_SOURCE_WIDTH, fldr_pkg::SW_RESET);
		check_reg(fldr_pkg::REG_DISPLAY_WIDTH, fldr_pkg::DW_RESET);

		// reset widths: four undrawn lines, then a five-pixel bin of 200
		repeat (4) tab_item(fldr_pkg::OP_PIXEL, 8'd0, 1'b1);
		repeat (4) tab_item(fldr_pkg::OP_PIXEL, 8'd200, 1'b0);
		tab_item(fldr_pkg::OP_PIXEL, 8'd200, 1'b1);
		tab_result(16'hCE59, 9'd0, 8'd0, 1'b0, 1'b0);
		// one source pixel per column
		tab_cfg(fldr_pkg::REG_SOURCE_WIDTH, 12'd4);
		tab_cfg(fldr_pkg::REG_DISPLAY_WIDTH, 12'd4);
		tab_item(fldr_pkg::OP_NEW_IMAGE, 8'd0, 1'b0);
		tab_item(fldr_pkg::OP_PIXEL, 8'd0, 1'b0);
		tab_result(16'h0000, 9'd0, 8'd0, 1'b0, 1'b0);
		tab_item(fldr_pkg::OP_PIXEL, 8'd255, 1'b0);
		tab_result(16'hFFFF, 9'd1, 8'd0, 1'b0, 1'b0);
		tab_item(fldr_pkg::OP_PIXEL, 8'd128, 1'b0);
		tab_result(16'h8410, 9'd2, 8'd0, 1'b0, 1'b0);
		tab_item(fldr_pkg::OP_PIXEL, 8'd127, 1'b1);
		tab_result(16'h7BEF, 9'd3, 8'd0, 1'b1, 1'b0);
		// short line, then a long one whose tail is ignored
		tab_item(fldr_pkg::OP_PIXEL, 8'h55, 1'b1);
		repeat (4) tab_item(fldr_pkg::OP_PIXEL, 8'($urandom), 1'b0);
		tab_item(fldr_pkg::OP_PIXEL, 8'hAA, 1'b1);
		// display wider than source and past the column limit
		tab_cfg(fldr_pkg::REG_SOURCE_WIDTH, 12'd1);
		tab_cfg(fldr_pkg::REG_DISPLAY_WIDTH, 12'd600);
		tab_item(fldr_pkg::OP_PIXEL, 8'd255, 1'b1);
		// zero widths hold everything
		tab_cfg(fldr_pkg::REG_DISPLAY_WIDTH, 12'd0);
		tab_item(fldr_pkg::OP_PIXEL, 8'd0, 1'b1);
		tab_cfg(fldr_pkg::REG_SOURCE_WIDTH, 12'd0);
		tab_cfg(fldr_pkg::REG_DISPLAY_WIDTH, 12'd5);
		tab_item(fldr_pkg::OP_PIXEL, 8'd255, 1'b1);

		foreach (dir_rows[k]) begin
			if (dir_rows[k].is_cfg) begin
				drain_px();
				write_width(dir_rows[k].ridx, dir_rows[k].val);
			end else begin
				send_item(dir_rows[k].it, dir_rows[k].typed, dir_rows[k].res);
			end
		end

		start = items_sent;
		phase_no = 0;
		while (items_sent - start < RAND_ITEMS) begin
			if (phase_no == 0)
				ph = PH_WRAP;
			else if (phase_no == 1)
				ph = PH_BIN_WRAP;
			else begin
				r = $urandom_range(0, 9);
				if (r == 0)
					ph = PH_SAME;
				else if (r == 5)
					ph = PH_UP;
				else if (r == 6)
					ph = PH_WIDE;
				else if (r == 7)
					ph = PH_ZERO;
				else if (r == 8)
					ph = PH_EXTREME;
				else
					ph = PH_DOWN;
			end
			case (ph)
				PH_SAME: begin
					sw = 12'($urandom_range(1, 8));
					dw = sw;
				end
				PH_UP: begin
					sw = 12'($urandom_range(1, 16));
					dw = 12'($urandom_range(sw + 1, 40));
				end
				PH_WIDE: begin
					sw = 12'($urandom_range(1, 64));
					dw = 12'($urandom_range(513, 4095));
				end
				PH_ZERO: begin
					if ($urandom_range(0, 1)) begin
						sw = '0;
						dw = 12'($urandom_range(0, 20));
					end else begin
						sw = 12'($urandom_range(1, 20));
						dw = '0;
					end
				end
				PH_EXTREME: begin
					case ($urandom_range(0, 2))
						0: sw = 12'd1;
						1: sw = 12'd2048;
						default: sw = 12'd4095;
					endcase
					case ($urandom_range(0, 3))
						0: dw = 12'd1;
						1: dw = 12'd512;
						2: dw = 12'd4095;
						default: dw = sw;
					endcase
				end
				PH_WRAP: begin
					sw = 12'($urandom_range(1, 3));
					dw = sw;
				end
				PH_BIN_WRAP: begin
					sw = 12'($urandom_range(300, 400));
					dw = 12'd1;
				end
				default: begin
					sw = 12'($urandom_range(1, 48));
					dw = 12'($urandom_range(1, sw));
				end
			endcase

			drain_px();
			write_width(fldr_pkg::REG_SOURCE_WIDTH, sw);
			write_width(fldr_pkg::REG_DISPLAY_WIDTH, dw);
			in_gap_max = pick_gap();
			out_gap_max = pick_gap();
			if (ph != PH_WRAP && $urandom_range(0, 1)) begin
				it.operation = fldr_pkg::OP_NEW_IMAGE;
				it.pixel = 8'($urandom);
				it.line_end = 1'($urandom);
				send_item(it, 1'b0, none);
			end

			if (ph == PH_WRAP)
				n_lines = 200;
			else if (ph == PH_BIN_WRAP)
				n_lines = 1;
			else
				n_lines = $urandom_range(4, 16);
			for (int unsigned ln = 0; ln < n_lines; ln++) begin
				noisy = 1'b0;
				if (sw == 0)
					base = $urandom_range(1, 8);
				else if (sw <= 64)
					base = 32'(sw);
				else
					base = $urandom_range(1, 64);
				r = $urandom_range(0, 99);
				if (ph == PH_WRAP || ph == PH_BIN_WRAP)
					len = 32'(sw);
				else if (r < 70)
					len = base;
				else if (r < 85)
					len = $urandom_range(1, base);
				else if (r < 95)
					len = base + $urandom_range(1, 4);
				else begin
					len = $urandom_range(1, 8);
					noisy = 1'b1;
				end
				send_line(len, noisy, ph == PH_BIN_WRAP);
			end
			phase_no++;
		end

		drain_px();
		if (mismatches == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

	initial begin : watchdog
		#6000000;
		$display("tb: FAIL");
		$finish;
	end

endmodule

// ===== files.f =====
hdl/fldr_pkg.sv
hdl/fldr_regs.sv
hdl/fldr_div.sv
hdl/fldr_dp.sv
hdl/fldr_ctrl.sv
hdl/fax_line_downscaler_rgb565.sv
hdl/fldr_checker.sv
verif/tb.sv
